@@ rtl/core/emc_pkg.sv @@
// Shared types and constants for the endpoint-to-locator map cache.
package emc_pkg;

  localparam int OP_W       = 2;
  localparam int HALF_W     = 64;
  localparam int TICK_W     = 32;
  localparam int CNT_OUT_W  = 5;
  localparam int ENTRY_W    = 4 * HALF_W + TICK_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

@@ rtl/core/emc_ctrl.sv @@
// Sequencer for the map cache: accept, scan, commit, hand off to output register.
module emc_ctrl import emc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read is still being compared
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  end

  // no transfer is taken while reset is asserted
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/emc_dpath.sv @@
// Datapath: entry memory, valid marks, insertion ranks, scan compare and result registers.
module emc_dpath import emc_pkg::*; #(
  parameter int CACHE_SIZE = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [HALF_W-1:0]    in_eid_hi,
  input  logic [HALF_W-1:0]    in_eid_lo,
  input  logic [HALF_W-1:0]    in_rloc_hi,
  input  logic [HALF_W-1:0]    in_rloc_lo,
  input  logic [TICK_W-1:0]    in_now_tick,
  output logic                 out_hit,
  output logic [HALF_W-1:0]    out_found_rloc_hi,
  output logic [HALF_W-1:0]    out_found_rloc_lo,
  output logic [TICK_W-1:0]    out_found_age,
  output logic                 out_added,
  output logic                 out_evicted,
  output logic [CNT_OUT_W-1:0] out_entry_count
);

  localparam int IDX_W  = (CACHE_SIZE > 1) ? $clog2(CACHE_SIZE) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(CACHE_SIZE + 1);

  // entry memory: {key_hi, key_lo, loc_hi, loc_lo, age}
  logic [ENTRY_W-1:0] mem [CACHE_SIZE];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [CACHE_SIZE-1:0] valid_r, valid_nxt;
  logic [RANK_W-1:0]     rank_r   [CACHE_SIZE];
  logic [RANK_W-1:0]     rank_nxt [CACHE_SIZE];
  logic [CNT_W-1:0]      count_r, count_nxt;

  op_t               req_op_r;
  logic [HALF_W-1:0] req_key_hi_r, req_key_lo_r, req_loc_hi_r, req_loc_lo_r;
  logic [TICK_W-1:0] req_tick_r;

  logic [IDX_W-1:0]  scan_addr_r;
  logic              cmp_en_r;
  logic [IDX_W-1:0]  cmp_idx_r;

  logic              match_found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [HALF_W-1:0] match_loc_hi_r, match_loc_lo_r;
  logic [TICK_W-1:0] match_age_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [IDX_W-1:0]  oldest_idx_r;

  logic [HALF_W-1:0] rd_key_hi, rd_key_lo, rd_loc_hi, rd_loc_lo;
  logic [TICK_W-1:0] rd_age;
  logic              cmp_valid, cmp_hit, cmp_oldest;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic              full;
  logic [RANK_W-1:0] match_rank;

  logic                 res_hit, res_added, res_evicted;
  logic [HALF_W-1:0]    res_loc_hi, res_loc_lo;
  logic [TICK_W-1:0]    res_age;
  logic                 res_hit_r, res_added_r, res_evicted_r;
  logic [HALF_W-1:0]    res_loc_hi_r, res_loc_lo_r;
  logic [TICK_W-1:0]    res_age_r;
  logic [CNT_OUT_W-1:0] res_cnt_r;

  logic                 out_hit_r, out_added_r, out_evicted_r;
  logic [HALF_W-1:0]    out_loc_hi_r, out_loc_lo_r;
  logic [TICK_W-1:0]    out_age_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  assign sts.scan_last = (scan_addr_r == IDX_W'(CACHE_SIZE - 1));

  // memory: one registered read per scan cycle, one write at commit
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r <= mem[scan_addr_r];
    end
    if (wr_en) begin
      mem[wr_idx] <= {req_key_hi_r, req_key_lo_r, req_loc_hi_r, req_loc_lo_r, req_tick_r};
    end
  end

  assign {rd_key_hi, rd_key_lo, rd_loc_hi, rd_loc_lo, rd_age} = rd_data_r;

  assign cmp_valid  = valid_r[cmp_idx_r];
  assign cmp_hit    = cmp_valid && (rd_key_hi == req_key_hi_r) && (rd_key_lo == req_key_lo_r);
  assign cmp_oldest = cmp_valid && (CNT_W'(rank_r[cmp_idx_r]) == (count_r - CNT_W'(1)));

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op_r     <= op_t'(in_opcode);
      req_key_hi_r <= in_eid_hi;
      req_key_lo_r <= in_eid_lo;
      req_loc_hi_r <= in_rloc_hi;
      req_loc_lo_r <= in_rloc_lo;
      req_tick_r   <= in_now_tick;
    end
    cmp_idx_r <= scan_addr_r;
    if (cmp_en_r) begin
      if (cmp_hit && !match_found_r) begin
        match_idx_r    <= cmp_idx_r;
        match_loc_hi_r <= rd_loc_hi;
        match_loc_lo_r <= rd_loc_lo;
        match_age_r    <= rd_age;
      end
      if (!cmp_valid && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
      if (cmp_oldest) begin
        oldest_idx_r <= cmp_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r   <= '0;
      cmp_en_r      <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.load) begin
        scan_addr_r   <= '0;
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_addr_r <= scan_addr_r + IDX_W'(1);
        end
        if (cmp_en_r && cmp_hit) begin
          match_found_r <= 1'b1;
        end
        if (cmp_en_r && !cmp_valid) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  assign match_rank = rank_r[match_idx_r];
  assign full       = (count_r == CNT_W'(CACHE_SIZE));

  // table update at commit
  always_comb begin
    valid_nxt   = valid_r;
    rank_nxt    = rank_r;
    count_nxt   = count_r;
    wr_en       = 1'b0;
    wr_idx      = full ? oldest_idx_r : free_idx_r;
    res_hit     = match_found_r;
    res_loc_hi  = match_found_r ? match_loc_hi_r : '0;
    res_loc_lo  = match_found_r ? match_loc_lo_r : '0;
    res_age     = match_found_r ? match_age_r : '0;
    res_added   = 1'b0;
    res_evicted = 1'b0;
    if (cmd.commit) begin
      case (req_op_r)
        OP_LOOKUP: begin
        end
        OP_REMOVE: begin
          if (match_found_r) begin
            valid_nxt[match_idx_r] = 1'b0;
            for (int j = 0; j < CACHE_SIZE; j++) begin
              if (valid_r[j] && (rank_r[j] > match_rank)) begin
                rank_nxt[j] = rank_r[j] - RANK_W'(1);
              end
            end
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_UPDATE: begin
          if (!match_found_r && (full || free_found_r)) begin
            // a full table reuses the oldest slot; everyone else ages by one
            for (int j = 0; j < CACHE_SIZE; j++) begin
              if (valid_r[j]) begin
                rank_nxt[j] = rank_r[j] + RANK_W'(1);
              end
            end
            rank_nxt[wr_idx]  = '0;
            valid_nxt[wr_idx] = 1'b1;
            wr_en             = 1'b1;
            count_nxt         = full ? count_r : count_r + CNT_W'(1);
            res_age           = req_tick_r;
            res_added         = 1'b1;
            res_evicted       = full;
          end
        end
        OP_CLEAR: begin
          valid_nxt  = '0;
          count_nxt  = '0;
          res_hit    = 1'b0;
          res_loc_hi = '0;
          res_loc_lo = '0;
          res_age    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    if (cmd.commit) begin
      res_hit_r     <= res_hit;
      res_loc_hi_r  <= res_loc_hi;
      res_loc_lo_r  <= res_loc_lo;
      res_age_r     <= res_age;
      res_added_r   <= res_added;
      res_evicted_r <= res_evicted;
      res_cnt_r     <= CNT_OUT_W'(count_nxt);
    end
    if (cmd.out_load) begin
      out_hit_r     <= res_hit_r;
      out_loc_hi_r  <= res_loc_hi_r;
      out_loc_lo_r  <= res_loc_lo_r;
      out_age_r     <= res_age_r;
      out_added_r   <= res_added_r;
      out_evicted_r <= res_evicted_r;
      out_cnt_r     <= res_cnt_r;
    end
  end

  assign out_hit           = out_hit_r;
  assign out_found_rloc_hi = out_loc_hi_r;
  assign out_found_rloc_lo = out_loc_lo_r;
  assign out_found_age     = out_age_r;
  assign out_added         = out_added_r;
  assign out_evicted       = out_evicted_r;
  assign out_entry_count   = out_cnt_r;

endmodule

@@ rtl/core/eid_rloc_map_cache.sv @@
// Top level of the endpoint-to-locator map cache with oldest-first replacement.
//
// Input channel (in_*): one operation per transfer: lookup, update/insert,
// remove by address or clear. Result channel (out_*): exactly one result per
// operation, in order, with hit, stored locator and age, added/evicted flags
// and the entry count after the operation.
//
// Each operation scans every entry of the entry memory, one read per cycle on
// its single read port, then passes a drain step, the commit and the load into
// the output register; a new item is taken only once the previous one is done.
// in_stall is high while an operation is in flight.
//
// The result sits in an output register; while the receiver stalls it is
// held, and the next item may be accepted and scanned meanwhile. Its result
// waits until the output register frees up.
//
// Reset clears all valid marks and the entry count; in_stall is high while
// reset is asserted and the cache is usable as soon as it is released.
module eid_rloc_map_cache import emc_pkg::*; #(
  parameter int CACHE_SIZE = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [HALF_W-1:0]    in_eid_hi,
  input  logic [HALF_W-1:0]    in_eid_lo,
  input  logic [HALF_W-1:0]    in_rloc_hi,
  input  logic [HALF_W-1:0]    in_rloc_lo,
  input  logic [TICK_W-1:0]    in_now_tick,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [HALF_W-1:0]    out_found_rloc_hi,
  output logic [HALF_W-1:0]    out_found_rloc_lo,
  output logic [TICK_W-1:0]    out_found_age,
  output logic                 out_added,
  output logic                 out_evicted,
  output logic [CNT_OUT_W-1:0] out_entry_count
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  emc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  emc_dpath #(
    .CACHE_SIZE (CACHE_SIZE)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_eid_hi         (in_eid_hi),
    .in_eid_lo         (in_eid_lo),
    .in_rloc_hi        (in_rloc_hi),
    .in_rloc_lo        (in_rloc_lo),
    .in_now_tick       (in_now_tick),
    .out_hit           (out_hit),
    .out_found_rloc_hi (out_found_rloc_hi),
    .out_found_rloc_lo (out_found_rloc_lo),
    .out_found_age     (out_found_age),
    .out_added         (out_added),
    .out_evicted       (out_evicted),
    .out_entry_count   (out_entry_count)
  );

endmodule

@@ rtl/core/emc_checker.sv @@
// Port-level checks for the map cache, bound to the top level.
module emc_checker import emc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_hit,
  input logic [HALF_W-1:0]    out_found_rloc_hi,
  input logic [HALF_W-1:0]    out_found_rloc_lo,
  input logic [TICK_W-1:0]    out_found_age,
  input logic                 out_added,
  input logic                 out_evicted,
  input logic [CNT_OUT_W-1:0] out_entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_count) && $stable(out_hit))
    else $error("stalled result changed or dropped");

  a_hit_xor_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_added))
    else $error("result reports both hit and insert");

  a_evict_needs_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_added)
    else $error("eviction without insert");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_rloc_hi == '0 && out_found_rloc_lo == '0)
    else $error("locator nonzero on miss");

endmodule

bind eid_rloc_map_cache emc_checker u_emc_checker (.*);
